// ===== hdl/can_bts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, constants and helper functions of the CAN bit timing search.
package can_bts_pkg;

	localparam int CLK_W   = 27;
	localparam int RATE_W  = 20;
	localparam int TOL_W   = 20;
	localparam int PRESC_W = 11;
	localparam int PS1_W   = 5;
	localparam int PS2_W   = 4;
	localparam int SJW_W   = 3;
	localparam int ACT_W   = 25;
	localparam int PPM_W   = 22;
	localparam int SMP_W   = 7;
	localparam int Q_W     = 5;
	localparam int D_W     = 25;
	localparam int W_W     = 36;
	localparam int SNUM_W  = 11;

	// Operand widths and step counter of the shared arithmetic unit.
	localparam int A_W   = 56;
	localparam int B_W   = 36;
	localparam int CNT_W = 6;

	localparam int MAX_PRESCALER_DEF = 1024;

	localparam logic [CLK_W-1:0]  CLK_RESET         = 27'd36000000;
	localparam logic [Q_W-1:0]    TQ_MAX            = 5'd25;
	localparam logic [Q_W-1:0]    TQ_MIN            = 5'd5;
	localparam logic [PS2_W-1:0]  SJW_CAP           = 4'd4;
	localparam logic [RATE_W-1:0] TRIPLE_RATE_LIMIT = 20'd125000;
	localparam logic [RATE_W-1:0] PPM_SCALE         = 20'd1000000;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic             start;
		arith_op_t        op;
		logic [CNT_W-1:0] cycles;
	} arith_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	// Rate times 25, as shifts and adds.
	function automatic logic [D_W-1:0] mul25(input logic [RATE_W-1:0] r);
		logic [D_W-1:0] x;
		x = D_W'(r);
		return (x << 4) + (x << 3) + x;
	endfunction

	// Phase segment 2 is 1 + 2q/7; 37/256 stands in for 1/7 over the narrow range of 2q.
	function automatic logic [PS2_W-1:0] ps2_of(input logic [Q_W-1:0] q);
		logic [10:0] t;
		t = 11'({q, 1'b0}) * 11'd37;
		return PS2_W'(t[10:8]) + PS2_W'(1);
	endfunction

	// (1 + phase_seg1) * 100 as shifts and adds.
	function automatic logic [SNUM_W-1:0] smp_num(input logic [PS1_W-1:0] ps1);
		logic [SNUM_W-1:0] x;
		x = SNUM_W'(ps1) + SNUM_W'(1);
		return (x << 6) + (x << 5) + (x << 2);
	endfunction

endpackage

// ===== hdl/can_bts_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and clock configuration.
interface can_bts_req_if import can_bts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] wished_bit_rate;
	logic [TOL_W-1:0]  tolerance_ppm;

	modport source(output valid, output wished_bit_rate, output tolerance_ppm, input ready);
	modport sink(input valid, input wished_bit_rate, input tolerance_ppm, output ready);
endinterface

interface can_bts_rsp_if import can_bts_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRESC_W-1:0] prescaler;
	logic [PS1_W-1:0]   phase_seg1;
	logic [PS2_W-1:0]   phase_seg2;
	logic [SJW_W-1:0]   sync_jump_width;
	logic               triple_sampling;
	logic               within_tolerance;
	logic [ACT_W-1:0]   actual_bit_rate;
	logic [PPM_W-1:0]   ppm_error;
	logic [SMP_W-1:0]   sample_point_percent;
	logic               exact_rate;

	modport source(output valid, output prescaler, output phase_seg1, output phase_seg2,
		output sync_jump_width, output triple_sampling, output within_tolerance,
		output actual_bit_rate, output ppm_error, output sample_point_percent,
		output exact_rate, input ready);
	modport sink(input valid, input prescaler, input phase_seg1, input phase_seg2,
		input sync_jump_width, input triple_sampling, input within_tolerance,
		input actual_bit_rate, input ppm_error, input sample_point_percent,
		input exact_rate, output ready);
endinterface

interface can_bts_cfg_if import can_bts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CLK_W-1:0] can_clock_hz;

	modport source(output valid, output can_clock_hz, input ready);
	modport sink(input valid, input can_clock_hz, output ready);
endinterface

// ===== hdl/can_bts_arith.sv =====
`timescale 1ns / 1ps
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit a cycle.
module can_bts_arith import can_bts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  arith_ctl_t       ctl,
	input  logic [A_W-1:0]   opnd_a,
	input  logic [B_W-1:0]   opnd_b,
	output arith_sts_t       sts,
	output logic [A_W-1:0]   prod,
	output logic [A_W-1:0]   quot,
	output logic [B_W-1:0]   rem
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	arith_op_t        op_q;

	logic [A_W-1:0] x_q;
	logic [B_W-1:0] y_q;
	logic [A_W-1:0] z_q;
	logic [B_W-1:0] b_q;

	logic [B_W:0] div_trial;
	logic [B_W:0] div_diff;
	logic         div_ge;

	always_comb begin
		div_trial = {y_q, x_q[A_W-1]};
		div_diff  = div_trial - {1'b0, b_q};
		div_ge    = div_trial >= {1'b0, b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.cycles;
				op_q   <= ctl.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// In a multiply x is the shifting multiplicand and b the multiplier; in a divide x
	// shifts the dividend out and the quotient in, and y holds the partial remainder.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= opnd_a;
			y_q <= '0;
			z_q <= '0;
			b_q <= opnd_b;
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					z_q <= z_q + (b_q[0] ? x_q : '0);
					x_q <= x_q << 1;
					b_q <= b_q >> 1;
				end
				OP_DIV: begin
					x_q <= {x_q[A_W-2:0], div_ge};
					// The partial remainder stays below the divisor, so it fits in B_W bits.
					y_q <= div_ge ? div_diff[B_W-1:0] : div_trial[B_W-1:0];
				end
				default: begin
					x_q <= x_q;
				end
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = z_q;
	assign quot     = x_q;
	assign rem      = y_q;

endmodule

// ===== hdl/can_bit_timing_search.sv =====
`timescale 1ns / 1ps
// CAN bit timing search: top level with the search sequencer and result registers.
//
// A request beat on req carries a wanted bit rate and a tolerance in ppm. The block
// searches quanta counts from 25 down to 5 for the prescaler that gives the smallest
// clock error, then works out the segments, sample point and quality figures, and
// returns one response beat on rsp for every request.
// The peripheral clock is written on cfg (always ready); the user must write it only while no
// request is in hand, and the block itself does not enforce it. All arithmetic runs on one shared
// bit-serial multiply/divide unit. Each quanta count tried costs a 27-step division and the
// two candidate compares, at most 21 counts are tried, and the final figures follow, the
// largest part being a 56-step division for the ppm error. For a zero rate neither the
// search nor the ppm division runs. req.ready is low from acceptance until the response
// is loaded into the output register.
// The finished result sits in an output register, so a new request is taken while
// the previous response still waits; if the receiver stalls, the block holds the
// next result until the register is free.
// Reset clears the sequencer and the response valid, and sets the clock to 36 MHz.
module can_bit_timing_search import can_bts_pkg::*; #(
	parameter int MAX_PRESCALER = MAX_PRESCALER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	can_bts_req_if.sink   req,
	can_bts_rsp_if.source rsp,
	can_bts_cfg_if.sink   cfg
);

	localparam int PW = $clog2(MAX_PRESCALER + 1);

	typedef enum logic [14:0] {
		S_IDLE    = 15'b000000000000001,
		S_INIT    = 15'b000000000000010,
		S_DIV     = 15'b000000000000100,
		S_CAND_LO = 15'b000000000001000,
		S_CAND_HI = 15'b000000000010000,
		S_NEXT    = 15'b000000000100000,
		S_WMUL    = 15'b000000001000000,
		S_DIFF    = 15'b000000010000000,
		S_NUM     = 15'b000000100000000,
		S_DEN     = 15'b000001000000000,
		S_PPM     = 15'b000010000000000,
		S_PQ      = 15'b000100000000000,
		S_ACT     = 15'b001000000000000,
		S_SMP     = 15'b010000000000000,
		S_OUT     = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	logic [CLK_W-1:0] clk_q;
	logic             found_q;
	logic             rsp_valid_q;

	logic [RATE_W-1:0] rate_q;
	logic [TOL_W-1:0]  tol_q;
	logic [Q_W-1:0]    q_q;
	logic [D_W-1:0]    d_q;
	logic [PW-1:0]     p_q;
	logic [D_W-1:0]    r_q;
	logic [PW-1:0]     best_p_q;
	logic [Q_W-1:0]    best_q_q;
	logic [D_W-1:0]    best_d_q;
	logic [D_W-1:0]    best_err_q;
	logic [W_W-1:0]    w_q;
	logic [A_W-1:0]    num_q;
	logic              within_q;
	logic              exact_q;
	logic [PPM_W-1:0]  ppm_q;
	logic [ACT_W-1:0]  act_q;
	logic [SMP_W-1:0]  smp_q;

	logic [PRESC_W-1:0] out_presc_q;
	logic [PS1_W-1:0]   out_ps1_q;
	logic [PS2_W-1:0]   out_ps2_q;
	logic [SJW_W-1:0]   out_sjw_q;
	logic               out_triple_q;
	logic               out_within_q;
	logic [ACT_W-1:0]   out_act_q;
	logic [PPM_W-1:0]   out_ppm_q;
	logic [SMP_W-1:0]   out_smp_q;
	logic               out_exact_q;

	arith_ctl_t     ctl;
	arith_sts_t     sts;
	logic [A_W-1:0] opnd_a;
	logic [B_W-1:0] opnd_b;
	logic [A_W-1:0] arith_prod;
	logic [A_W-1:0] arith_quot;
	logic [B_W-1:0] arith_rem;

	logic             p_over;
	logic [D_W-1:0]   err_hi;
	logic             lo_take;
	logic             hi_take;
	logic [W_W-1:0]   clk_ext;
	logic [W_W-1:0]   diff_c;
	logic [PS2_W-1:0] ps2_c;
	logic [PS1_W-1:0] ps1_c;
	logic [SJW_W-1:0] sjw_c;
	logic             triple_c;
	logic             out_load;

	can_bts_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opnd_a (opnd_a),
		.opnd_b (opnd_b),
		.sts    (sts),
		.prod   (arith_prod),
		.quot   (arith_quot),
		.rem    (arith_rem)
	);

	always_comb begin
		p_over   = arith_quot > A_W'(MAX_PRESCALER);
		err_hi   = d_q - r_q;
		lo_take  = (p_q != '0) && (!found_q || (r_q < best_err_q));
		hi_take  = (p_q < PW'(MAX_PRESCALER)) && (!found_q || (err_hi < best_err_q));
		clk_ext  = W_W'(clk_q);
		diff_c   = (clk_ext > w_q) ? (clk_ext - w_q) : (w_q - clk_ext);
		ps2_c    = ps2_of(best_q_q);
		ps1_c    = best_q_q - PS1_W'(ps2_c) - PS1_W'(1);
		sjw_c    = (ps2_c >= SJW_CAP) ? SJW_W'(SJW_CAP) : ps2_c[SJW_W-1:0];
		triple_c = (rate_q <= TRIPLE_RATE_LIMIT) && (ps1_c > PS1_W'(1));
		out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);
	end

	// Sequencer: each state that launches work on the shared unit does so on its way out.
	always_comb begin
		state_d    = state_q;
		ctl.start  = 1'b0;
		ctl.op     = OP_MUL;
		ctl.cycles = '0;
		opnd_a     = '0;
		opnd_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				if (rate_q == '0) begin
					ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(PW)};
					opnd_a  = A_W'(best_d_q);
					opnd_b  = B_W'(best_p_q);
					state_d = S_WMUL;
				end else begin
					ctl     = '{start: 1'b1, op: OP_DIV, cycles: CNT_W'(CLK_W)};
					opnd_a  = {clk_q, {(A_W - CLK_W){1'b0}}};
					opnd_b  = B_W'(d_q);
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.done) begin
					if (p_over) begin
						ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(PW)};
						opnd_a  = A_W'(best_d_q);
						opnd_b  = B_W'(best_p_q);
						state_d = S_WMUL;
					end else begin
						state_d = S_CAND_LO;
					end
				end
			end
			S_CAND_LO: begin
				state_d = S_CAND_HI;
			end
			S_CAND_HI: begin
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (q_q == TQ_MIN) begin
					ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(PW)};
					opnd_a  = A_W'(best_d_q);
					opnd_b  = B_W'(best_p_q);
					state_d = S_WMUL;
				end else begin
					ctl     = '{start: 1'b1, op: OP_DIV, cycles: CNT_W'(CLK_W)};
					opnd_a  = {clk_q, {(A_W - CLK_W){1'b0}}};
					opnd_b  = B_W'(d_q - D_W'(rate_q));
					state_d = S_DIV;
				end
			end
			S_WMUL: begin
				if (sts.done) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(RATE_W)};
				opnd_a  = A_W'(diff_c);
				opnd_b  = B_W'(PPM_SCALE);
				state_d = S_NUM;
			end
			S_NUM: begin
				if (sts.done) begin
					ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(TOL_W)};
					opnd_a  = A_W'(w_q);
					opnd_b  = B_W'(tol_q);
					state_d = S_DEN;
				end
			end
			S_DEN: begin
				if (sts.done) begin
					if (w_q == '0) begin
						ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(Q_W)};
						opnd_a  = A_W'(best_p_q);
						opnd_b  = B_W'(best_q_q);
						state_d = S_PQ;
					end else begin
						ctl     = '{start: 1'b1, op: OP_DIV, cycles: CNT_W'(A_W)};
						opnd_a  = num_q;
						opnd_b  = B_W'(w_q);
						state_d = S_PPM;
					end
				end
			end
			S_PPM: begin
				if (sts.done) begin
					ctl     = '{start: 1'b1, op: OP_MUL, cycles: CNT_W'(Q_W)};
					opnd_a  = A_W'(best_p_q);
					opnd_b  = B_W'(best_q_q);
					state_d = S_PQ;
				end
			end
			S_PQ: begin
				if (sts.done) begin
					ctl     = '{start: 1'b1, op: OP_DIV, cycles: CNT_W'(CLK_W)};
					opnd_a  = {clk_q, {(A_W - CLK_W){1'b0}}};
					opnd_b  = arith_prod[B_W-1:0];
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				if (sts.done) begin
					ctl     = '{start: 1'b1, op: OP_DIV, cycles: CNT_W'(SNUM_W)};
					opnd_a  = {smp_num(ps1_c), {(A_W - SNUM_W){1'b0}}};
					opnd_b  = B_W'(best_q_q);
					state_d = S_SMP;
				end
			end
			S_SMP: begin
				if (sts.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clk_q       <= CLK_RESET;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				clk_q <= cfg.can_clock_hz;
			end
			if (state_q == S_IDLE && req.valid) begin
				found_q <= 1'b0;
			end else if ((state_q == S_CAND_LO && lo_take) ||
					(state_q == S_CAND_HI && hi_take)) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			rate_q     <= req.wished_bit_rate;
			tol_q      <= req.tolerance_ppm;
			q_q        <= TQ_MAX;
			d_q        <= mul25(req.wished_bit_rate);
			best_d_q   <= mul25(req.wished_bit_rate);
			best_p_q   <= PW'(MAX_PRESCALER);
			best_q_q   <= TQ_MAX;
			best_err_q <= '0;
		end
		if (state_q == S_DIV && sts.done) begin
			p_q <= arith_quot[PW-1:0];
			r_q <= arith_rem[D_W-1:0];
		end
		// Floor prescaler first, then the next one up; a tie keeps the earlier pair.
		if (state_q == S_CAND_LO && lo_take) begin
			best_err_q <= r_q;
			best_p_q   <= p_q;
			best_q_q   <= q_q;
			best_d_q   <= d_q;
		end
		if (state_q == S_CAND_HI && hi_take) begin
			best_err_q <= err_hi;
			best_p_q   <= p_q + PW'(1);
			best_q_q   <= q_q;
			best_d_q   <= d_q;
		end
		if (state_q == S_NEXT && q_q != TQ_MIN) begin
			q_q <= q_q - Q_W'(1);
			d_q <= d_q - D_W'(rate_q);
		end
		if (state_q == S_WMUL && sts.done) begin
			w_q <= arith_prod[W_W-1:0];
		end
		if (state_q == S_DIFF) begin
			exact_q <= clk_ext == w_q;
		end
		if (state_q == S_NUM && sts.done) begin
			num_q <= arith_prod;
		end
		if (state_q == S_DEN && sts.done) begin
			within_q <= num_q <= arith_prod;
			if (w_q == '0) begin
				ppm_q <= '1;
			end
		end
		if (state_q == S_PPM && sts.done) begin
			ppm_q <= (arith_quot[A_W-1:PPM_W] != '0) ? '1 : arith_quot[PPM_W-1:0];
		end
		if (state_q == S_ACT && sts.done) begin
			act_q <= arith_quot[ACT_W-1:0];
		end
		if (state_q == S_SMP && sts.done) begin
			smp_q <= arith_quot[SMP_W-1:0];
		end
		if (out_load) begin
			out_presc_q  <= PRESC_W'(best_p_q);
			out_ps1_q    <= ps1_c;
			out_ps2_q    <= ps2_c;
			out_sjw_q    <= sjw_c;
			out_triple_q <= triple_c;
			out_within_q <= within_q;
			out_act_q    <= act_q;
			out_ppm_q    <= ppm_q;
			out_smp_q    <= smp_q;
			out_exact_q  <= exact_q;
		end
	end

	assign req.ready                = state_q == S_IDLE;
	assign cfg.ready                = 1'b1;
	assign rsp.valid                = rsp_valid_q;
	assign rsp.prescaler            = out_presc_q;
	assign rsp.phase_seg1           = out_ps1_q;
	assign rsp.phase_seg2           = out_ps2_q;
	assign rsp.sync_jump_width      = out_sjw_q;
	assign rsp.triple_sampling      = out_triple_q;
	assign rsp.within_tolerance     = out_within_q;
	assign rsp.actual_bit_rate      = out_act_q;
	assign rsp.ppm_error            = out_ppm_q;
	assign rsp.sample_point_percent = out_smp_q;
	assign rsp.exact_rate           = out_exact_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !sts.busy)
		else $error("shared unit started while still busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while the previous one is still in hand");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_p_q != '0 && best_p_q <= PW'(MAX_PRESCALER)))
		else $error("chosen prescaler out of range");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && rsp_valid_q && !rsp.ready) |=> state_q == S_OUT)
		else $error("result overwrote a response beat that was not taken");

endmodule
